// ===== sv/lrip_pkg.sv =====
// Shared types, constants and the arctangent table for the lidar range image projector.
// No dependencies; the design modules refer to it by scoped names, the testbench files import it.
`default_nettype none
package lrip_pkg;
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 2048;
  localparam int CORDIC_STEPS = 16;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int RANGE_W = 20;
  localparam int ANG_W = 26;
  localparam int VEC_W = 31;

  localparam logic [1:0] OP_POINT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [6:0] ROWS_RESET = 7'd64;
  localparam logic [11:0] COLS_RESET = 12'd1800;
  localparam logic signed [ANG_W-1:0] DEG90 = 26'sd5898240;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [19:0] x_mm;
    logic signed [19:0] y_mm;
    logic [7:0]         ring;
    logic [5:0]         pixel_row;
    logic [10:0]        pixel_col;
  } item_t;

  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0: v = 26'sd2949120;   5'd1: v = 26'sd1740967;
      5'd2: v = 26'sd919879;    5'd3: v = 26'sd466945;
      5'd4: v = 26'sd234379;    5'd5: v = 26'sd117304;
      5'd6: v = 26'sd58666;     5'd7: v = 26'sd29335;
      5'd8: v = 26'sd14668;     5'd9: v = 26'sd7334;
      5'd10: v = 26'sd3667;     5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;       5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;       5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;        5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== sv/lrip_item_if.sv =====
// Input channel of the projector: valid/ready plus the item fields.
// Depends on nothing.
`default_nettype none
interface lrip_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [19:0] x_mm;
  logic signed [19:0] y_mm;
  logic [7:0]         ring;
  logic [5:0]         pixel_row;
  logic [10:0]        pixel_col;
  modport source (output valid, op, x_mm, y_mm, ring, pixel_row, pixel_col, input ready);
  modport sink (input valid, op, x_mm, y_mm, ring, pixel_row, pixel_col, output ready);
endinterface
`default_nettype wire

// ===== sv/lrip_result_if.sv =====
// Result channel of the projector: valid/ready plus the result fields.
// Depends on nothing.
`default_nettype none
interface lrip_result_if;
  logic        valid;
  logic        ready;
  logic        point_stored;
  logic [19:0] range_mm;
  logic [7:0]  gray;
  logic [19:0] frame_min_mm;
  logic [19:0] frame_max_mm;
  logic        scale_invalid;
  modport source (output valid, point_stored, range_mm, gray, frame_min_mm, frame_max_mm,
                  scale_invalid, input ready);
  modport sink (input valid, point_stored, range_mm, gray, frame_min_mm, frame_max_mm,
                scale_invalid, output ready);
endinterface
`default_nettype wire

// ===== sv/lrip_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`default_nettype none
interface lrip_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/lidar_range_image_projection.sv =====
// Lidar range image projector: projects points into a 64 x 2048 range image,
// tracks frame min/max, and reads pixels back with a gray value.
// Depends on lrip_pkg, the three channel interfaces, lrip_front and lrip_back.
//
// Channels: item (op, point, ring, pixel address) in, result out, cfg writes
// rows_in_use (index 0) and columns_in_use (index 1); cfg is always ready.
// Every item gives exactly one result transaction.
// Steps per item: a point squares x, adds the square of y, then takes the rounded
// square root, one root bit per cycle for 20 bits, while the CORDIC runs; a read
// does a memory read plus a bit-serial divide for the gray value; frame and no-op
// go straight to the result register. One item runs in the back end at a time,
// and the next is taken only once the last item's result is registered. A two-entry
// queue takes items while the back end works, and the result register lets the
// next item start while a result waits for the receiver; a stalled receiver fills
// the queue, then drops item.ready.
// Reset: config returns to 64 rows and 1800 columns, min/max clear, and the
// image is zeroed by a pass over all 131072 entries, one entry a cycle, during which
// no item is accepted.
`default_nettype none
module lidar_range_image_projection (
  input  wire logic     clk,
  input  wire logic     rst,
  lrip_item_if.sink     item,
  lrip_result_if.source result,
  lrip_cfg_if.sink      cfg
);
  logic [6:0]  rows_in_use;
  logic [11:0] columns_in_use;
  logic        clearing;
  logic        q_pop;
  logic        q_valid;
  lrip_pkg::item_t q_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= lrip_pkg::ROWS_RESET;
      columns_in_use <= lrip_pkg::COLS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lrip_pkg::REG_ROWS: rows_in_use <= cfg.data[6:0];
        lrip_pkg::REG_COLS: columns_in_use <= cfg.data;
        default: ;
      endcase
    end
  end

  lrip_front u_front (
    .clk(clk), .rst(rst), .item(item), .hold(clearing),
    .q_pop(q_pop), .q_valid(q_valid), .q_item(q_item)
  );

  lrip_back u_back (
    .clk(clk), .rst(rst), .rows_in_use(rows_in_use), .columns_in_use(columns_in_use),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .clearing(clearing),
    .o_valid(result.valid), .o_ready(result.ready), .o_stored(result.point_stored),
    .o_range(result.range_mm), .o_gray(result.gray), .o_min(result.frame_min_mm),
    .o_max(result.frame_max_mm), .o_bad(result.scale_invalid)
  );
endmodule
`default_nettype wire

// ===== sv/lrip_front.sv =====
// Front end: accepts input transactions into a two-entry queue for the back end.
// Depends on lrip_pkg and lrip_item_if.
`default_nettype none
module lrip_front (
  input  wire logic          clk,
  input  wire logic          rst,
  lrip_item_if.sink          item,
  input  wire logic          hold,
  input  wire logic          q_pop,
  output logic               q_valid,
  output lrip_pkg::item_t    q_item
);
  lrip_pkg::item_t buf_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign item.ready = (count != 2'd2) && !hold;
  assign push = item.valid && item.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_pop && q_valid;
  assign q_item = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= '{op: item.op, x_mm: item.x_mm, y_mm: item.y_mm, ring: item.ring,
                         pixel_row: item.pixel_row, pixel_col: item.pixel_col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/lrip_sqrt.sv =====
// Range unit: squares x and then y in turn, then a rounded
// digit-by-digit square root, one result bit per cycle. Depends on lrip_pkg.
`default_nettype none
module lrip_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [19:0]             x_mm,
  input  wire logic signed [19:0]             y_mm,
  output logic                                done,
  output logic [lrip_pkg::RANGE_W-1:0]        root
);
  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_Y    = 2'd1;
  localparam logic [1:0] SQ_ROOT = 2'd2;
  localparam logic [1:0] SQ_RND  = 2'd3;

  logic [1:0]  phase;
  logic [4:0]  cnt;
  logic [19:0] ya;
  logic [39:0] sq;
  logic [19:0] q;
  logic [21:0] rem;
  logic [19:0] xa;
  logic [23:0] remx;
  logic [23:0] trial;

  assign xa = x_mm[19] ? 20'(-x_mm) : x_mm;
  assign remx = {rem, sq[39:38]};
  assign trial = {2'b00, q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SQ_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        SQ_IDLE: begin
          if (start) begin
            sq <= xa * xa;
            ya <= y_mm[19] ? 20'(-y_mm) : y_mm;
            phase <= SQ_Y;
          end
        end
        SQ_Y: begin
          sq <= sq + ya * ya;
          q <= '0;
          rem <= '0;
          cnt <= 5'd19;
          phase <= SQ_ROOT;
        end
        SQ_ROOT: begin
          sq <= {sq[37:0], 2'b00};
          if (remx >= trial) begin
            rem <= 22'(remx - trial);
            q <= {q[18:0], 1'b1};
          end else begin
            rem <= remx[21:0];
            q <= {q[18:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) phase <= SQ_RND;
        end
        SQ_RND: begin
          root <= (rem > {2'b00, q}) ? q + 20'd1 : q;
          done <= 1'b1;
          phase <= SQ_IDLE;
        end
        default: phase <= SQ_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/lrip_cordic.sv =====
// Angle unit: iterative vectoring CORDIC giving atan2(x, y) in degrees * 2^16,
// one rotation per cycle after a quadrant pre-rotation. Depends on lrip_pkg.
`default_nettype none
module lrip_cordic (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [19:0]                x_mm,
  input  wire logic signed [19:0]                y_mm,
  output logic                                   done,
  output logic signed [lrip_pkg::ANG_W-1:0]      angle
);
  localparam int VW = lrip_pkg::VEC_W;
  localparam int AW = lrip_pkg::ANG_W;

  logic                 busy;
  logic [4:0]           step;
  logic signed [VW-1:0] a;
  logic signed [VW-1:0] b;
  logic signed [AW-1:0] z;
  logic signed [VW-1:0] a0;
  logic signed [VW-1:0] b0;
  logic signed [VW-1:0] da;
  logic signed [VW-1:0] db;

  assign a0 = VW'(y_mm) <<< 8;
  assign b0 = VW'(x_mm) <<< 8;
  assign da = b >>> step;
  assign db = a >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (x_mm == '0 && y_mm == '0) begin
          angle <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (a0 < 0) begin
            if (b0 >= 0) begin
              a <= b0; b <= -a0; z <= lrip_pkg::DEG90;
            end else begin
              a <= -b0; b <= a0; z <= -lrip_pkg::DEG90;
            end
          end else begin
            a <= a0; b <= b0; z <= '0;
          end
        end
      end else if (busy) begin
        if (b >= 0) begin
          a <= a + da; b <= b - db; z <= z + lrip_pkg::atan_tab(step);
        end else begin
          a <= a - da; b <= b + db; z <= z - lrip_pkg::atan_tab(step);
        end
        step <= step + 5'd1;
        if (step == 5'(lrip_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          angle <= (b >= 0) ? z + lrip_pkg::atan_tab(step) : z - lrip_pkg::atan_tab(step);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/lrip_back.sv =====
// Back end: sequencer that runs one queued transaction at a time, owns the range
// image memory, frame min/max, gray divider and the result register.
// Depends on lrip_pkg, lrip_sqrt and lrip_cordic.
`default_nettype none
module lrip_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [6:0]          rows_in_use,
  input  wire logic [11:0]         columns_in_use,
  input  wire logic                q_valid,
  input  wire lrip_pkg::item_t     q_item,
  output logic                     q_pop,
  output logic                     clearing,
  output logic                     o_valid,
  input  wire logic                o_ready,
  output logic                     o_stored,
  output logic [19:0]              o_range,
  output logic [7:0]               o_gray,
  output logic [19:0]              o_min,
  output logic [19:0]              o_max,
  output logic                     o_bad
);
  localparam int AW = lrip_pkg::ADDR_W;
  localparam logic [3:0] B_CLR  = 4'd0;
  localparam logic [3:0] B_IDLE = 4'd1;
  localparam logic [3:0] B_WAIT = 4'd2;
  localparam logic [3:0] B_BIN  = 4'd3;
  localparam logic [3:0] B_COL  = 4'd4;
  localparam logic [3:0] B_WR   = 4'd5;
  localparam logic [3:0] B_RD   = 4'd6;
  localparam logic [3:0] B_RD2  = 4'd7;
  localparam logic [3:0] B_DIV  = 4'd8;
  localparam logic [3:0] B_OUT  = 4'd9;

  logic [3:0]  state;
  logic [AW-1:0] clr_addr;
  lrip_pkg::item_t cur;
  logic [19:0] mem [lrip_pkg::DEPTH];
  logic [19:0] rd_data;
  logic        we;
  logic [AW-1:0] wa;
  logic [19:0] wd;
  logic        unit_start;
  logic        sq_done;
  logic        co_done;
  logic        sq_ok;
  logic        co_ok;
  logic [19:0] root;
  logic signed [lrip_pkg::ANG_W-1:0] angle;
  logic signed [28:0] m;
  logic signed [28:0] m_abs;
  logic [12:0] r_mag;
  logic signed [13:0] rbin;
  logic signed [13:0] col;
  logic signed [13:0] col_raw;
  logic [11:0] colsc;
  logic [6:0]  rowsc;
  logic        pt_ok;
  logic [19:0] rmax;
  logic [19:0] rmin;
  logic        res_stored;
  logic [19:0] res_range;
  logic [7:0]  res_gray;
  logic [19:0] dvs;
  logic [27:0] drem;
  logic [2:0]  dcnt;
  logic [27:0] dshift;

  assign clearing = (state == B_CLR);
  assign q_pop = (state == B_IDLE) && q_valid;
  assign unit_start = q_pop && (q_item.op == lrip_pkg::OP_POINT);
  assign colsc = (columns_in_use > 12'(lrip_pkg::MAX_COLS)) ? 12'(lrip_pkg::MAX_COLS)
                                                            : columns_in_use;
  assign rowsc = (rows_in_use > 7'(lrip_pkg::MAX_ROWS)) ? 7'(lrip_pkg::MAX_ROWS) : rows_in_use;
  assign m = (29'(angle) <<< 2) + 29'(angle);
  assign m_abs = m[28] ? -m : m;
  assign r_mag = 13'((m_abs + 29'sd32768) >>> 16);
  assign col_raw = 14'({2'b00, colsc[11:1]}) + 14'sd450 - rbin;
  assign pt_ok = ({1'b0, cur.ring} < {2'b00, rowsc}) && (col >= 0)
                 && (col < $signed({2'b00, colsc}));
  assign dshift = {8'd0, dvs} << dcnt;

  assign we = clearing || (state == B_WR && pt_ok);
  assign wa = clearing ? clr_addr : {cur.ring[lrip_pkg::ROW_W-1:0], col[lrip_pkg::COL_W-1:0]};
  assign wd = clearing ? '0 : res_range;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[{cur.pixel_row, cur.pixel_col}];
  end

  lrip_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(unit_start), .x_mm(q_item.x_mm), .y_mm(q_item.y_mm),
    .done(sq_done), .root(root)
  );

  lrip_cordic u_cordic (
    .clk(clk), .rst(rst), .start(unit_start), .x_mm(q_item.x_mm), .y_mm(q_item.y_mm),
    .done(co_done), .angle(angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLR;
      clr_addr <= '0;
      rmax <= '0;
      rmin <= '1;
      o_valid <= 1'b0;
      sq_ok <= 1'b0;
      co_ok <= 1'b0;
    end else begin
      if (o_valid && o_ready && state != B_OUT) o_valid <= 1'b0;
      unique case (state)
        B_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            res_stored <= 1'b0;
            res_range <= '0;
            res_gray <= '0;
            sq_ok <= 1'b0;
            co_ok <= 1'b0;
            unique case (q_item.op)
              lrip_pkg::OP_POINT: state <= B_WAIT;
              lrip_pkg::OP_READ:  state <= B_RD;
              lrip_pkg::OP_FRAME: begin
                rmax <= '0;
                rmin <= '1;
                state <= B_OUT;
              end
              lrip_pkg::OP_NOP:   state <= B_OUT;
              default:            state <= B_OUT;
            endcase
          end
        end
        B_WAIT: begin
          if (sq_done) begin
            sq_ok <= 1'b1;
            res_range <= root;
          end
          if (co_done) co_ok <= 1'b1;
          if ((sq_ok || sq_done) && (co_ok || co_done)) state <= B_BIN;
        end
        B_BIN: begin
          rbin <= m[28] ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
          state <= B_COL;
        end
        B_COL: begin
          col <= (col_raw >= $signed({2'b00, colsc})) ? col_raw - $signed({2'b00, colsc})
                                                      : col_raw;
          state <= B_WR;
        end
        B_WR: begin
          if (pt_ok) begin
            res_stored <= 1'b1;
            if (res_range > rmax) rmax <= res_range;
            if (res_range < rmin) rmin <= res_range;
          end
          state <= B_OUT;
        end
        B_RD: state <= B_RD2;
        B_RD2: begin
          res_range <= rd_data;
          dvs <= rmax - rmin;
          drem <= {rd_data, 8'd0} - {8'd0, rd_data};
          dcnt <= 3'd7;
          if (rmax <= rmin) state <= B_OUT;
          else if (({rd_data, 8'd0} - {8'd0, rd_data}) >= {rmax - rmin, 8'd0}) begin
            res_gray <= 8'hFF;
            state <= B_OUT;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (drem >= dshift) begin
            drem <= drem - dshift;
            res_gray[dcnt] <= 1'b1;
          end
          dcnt <= dcnt - 3'd1;
          if (dcnt == 3'd0) state <= B_OUT;
        end
        B_OUT: begin
          if (!o_valid || o_ready) begin
            o_valid <= 1'b1;
            o_stored <= res_stored;
            o_range <= res_range;
            o_gray <= res_gray;
            o_min <= rmin;
            o_max <= rmax;
            o_bad <= (rmax <= rmin);
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== test/lrip_projection_checker.sv =====
// Watches the item, result and configuration channels of the range image projector,
// predicts each result and compares it field by field. Depends on lrip_pkg and the
// three channel interfaces.
`timescale 1ns / 1ps
module lrip_projection_checker (
  input  logic clk,
  input  logic rst,
  lrip_item_if.sink   item,
  lrip_result_if.sink result,
  lrip_cfg_if.sink    cfg,
  output int          fail_count,
  output int          pending_count
);
  import lrip_pkg::*;

  typedef struct packed {
    logic        point_stored;
    logic [19:0] range_mm;
    logic [7:0]  gray;
    logic [19:0] frame_min_mm;
    logic [19:0] frame_max_mm;
    logic        scale_invalid;
  } pixel_result_t;

  localparam int ATAN_TAB [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  pixel_result_t expected_results[$];
  logic [19:0] image_model[int];
  logic [19:0] frame_max, frame_min;
  logic [6:0]  ring_count;
  logic [11:0] column_count;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint range_of(longint x, longint y);
    longint unsigned s, r, b, v;
    s = x * x + y * y;
    r = 0;
    b = 64'd1 << 62;
    v = s;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint azimuth_deg16(longint a, longint b);
    longint z, t, da, db;
    z = 0;
    if (a == 0 && b == 0) return 0;
    a *= 256;
    b *= 256;
    if (a < 0) begin
      t = a;
      if (b >= 0) begin
        a = b; b = -t; z = 5898240;
      end else begin
        a = -b; b = t; z = -5898240;
      end
    end
    for (int i = 0; i < 16; i++) begin
      da = floor_shift(b, i);
      db = floor_shift(a, i);
      if (b >= 0) begin
        a += da; b -= db; z += ATAN_TAB[i];
      end else begin
        a -= da; b += db; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic pixel_result_t project(logic [1:0] op, logic signed [19:0] x,
                                            logic signed [19:0] y, logic [7:0] ring,
                                            logic [5:0] prow, logic [10:0] pcol);
    pixel_result_t res;
    longint rows, cols, m, rb, col, rng;
    res = '0;
    if (op == OP_POINT) begin
      rows = ring_count > MAX_ROWS ? MAX_ROWS : ring_count;
      cols = column_count > MAX_COLS ? MAX_COLS : column_count;
      rng = range_of(x, y) & 20'hFFFFF;
      res.range_mm = rng[19:0];
      m = 5 * azimuth_deg16(y, x);
      rb = m >= 0 ? (m + 32768) >>> 16 : -(((-m) + 32768) >>> 16);
      col = cols / 2 + 450 - rb;
      if (col >= cols) col -= cols;
      if (ring < rows && col >= 0 && col < cols) begin
        image_model[int'(ring * MAX_COLS + col)] = rng[19:0];
        if (rng[19:0] > frame_max) frame_max = rng[19:0];
        if (rng[19:0] < frame_min) frame_min = rng[19:0];
        res.point_stored = 1'b1;
      end
    end else if (op == OP_READ) begin
      rng = image_model.exists(prow * MAX_COLS + pcol) ? image_model[prow * MAX_COLS + pcol] : 0;
      res.range_mm = rng[19:0];
      if (frame_max > frame_min) begin
        m = rng * 255 / (frame_max - frame_min);
        res.gray = m > 255 ? 8'd255 : m[7:0];
      end
    end else if (op == OP_FRAME) begin
      frame_max = '0;
      frame_min = '1;
    end
    res.frame_min_mm = frame_min;
    res.frame_max_mm = frame_max;
    res.scale_invalid = frame_max <= frame_min;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst) begin
      frame_max <= '0;
      frame_min <= '1;
      ring_count <= ROWS_RESET;
      column_count <= COLS_RESET;
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_ROWS) ring_count = cfg.data[6:0];
        else column_count = cfg.data;
      end
      if (item.valid && item.ready)
        expected_results.push_back(project(item.op, item.x_mm, item.y_mm, item.ring,
                                           item.pixel_row, item.pixel_col));
      if (result.valid && result.ready) begin
        got = '{result.point_stored, result.range_mm, result.gray, result.frame_min_mm,
                result.frame_max_mm, result.scale_invalid};
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (got.point_stored !== want.point_stored)
              $error("point_stored exp %0d got %0d", want.point_stored, got.point_stored);
            if (got.range_mm !== want.range_mm)
              $error("range_mm exp %0d got %0d", want.range_mm, got.range_mm);
            if (got.gray !== want.gray)
              $error("gray exp %0d got %0d", want.gray, got.gray);
            if (got.frame_min_mm !== want.frame_min_mm)
              $error("frame_min_mm exp %0d got %0d", want.frame_min_mm, got.frame_min_mm);
            if (got.frame_max_mm !== want.frame_max_mm)
              $error("frame_max_mm exp %0d got %0d", want.frame_max_mm, got.frame_max_mm);
            if (got.scale_invalid !== want.scale_invalid)
              $error("scale_invalid exp %0d got %0d", want.scale_invalid, got.scale_invalid);
          end
        end
      end
    end
  end
endmodule

// ===== test/lidar_range_image_projection_test.sv =====
// Top of the range image projector testbench: clock, reset, stimulus, receiver
// stalls and the verdict. Depends on lrip_pkg, the interfaces and the checker.
`timescale 1ns / 1ps
module lidar_range_image_projection_test;
  import lrip_pkg::*;

  logic clk, rst;
  int fail_count, pending_count;
  int sender_idle_pct, receiver_stall_pct;
  int hold_off_cycles;
  longint cycle_count;
  logic [5:0] written_row[$];
  logic [10:0] written_col[$];

  lrip_item_if item();
  lrip_result_if result();
  lrip_cfg_if cfg();

  lidar_range_image_projection i_dut (.clk(clk), .rst(rst), .item(item), .result(result),
                                      .cfg(cfg));
  lrip_projection_checker i_checker (.clk(clk), .rst(rst), .item(item), .result(result),
                                     .cfg(cfg), .fail_count(fail_count),
                                     .pending_count(pending_count));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3_000_000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      result.ready <= 1'b0;
    end else result.ready <= $urandom_range(99) >= receiver_stall_pct;
  end

  task automatic send(logic [1:0] op, logic signed [19:0] x, logic signed [19:0] y,
                      logic [7:0] ring, logic [5:0] prow, logic [10:0] pcol);
    while ($urandom_range(99) < sender_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.op <= op;
    item.x_mm <= x;
    item.y_mm <= y;
    item.ring <= ring;
    item.pixel_row <= prow;
    item.pixel_col <= pcol;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [11:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point();
    logic signed [19:0] x, y;
    logic [7:0] ring;
    case ($urandom_range(3))
      0: begin x = 20'($urandom); y = 20'($urandom); end
      1: begin
        x = $signed(20'($urandom_range(20000))) - 20'sd10000;
        y = $signed(20'($urandom_range(20000))) - 20'sd10000;
      end
      2: begin x = 20'($urandom_range(3)) - 20'sd1; y = 20'($urandom_range(3)) - 20'sd1; end
      default: begin
        x = 20'($urandom_range(100000));
        y = -$signed(20'($urandom_range(100000)));
      end
    endcase
    ring = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(70));
    send(OP_POINT, x, y, ring, '0, '0);
  endtask

  task automatic send_read();
    logic [5:0] r;
    logic [10:0] c;
    int k;
    if (written_row.size() > 0 && $urandom_range(3) != 0) begin
      k = int'($urandom_range(written_row.size() - 1));
      r = written_row[k];
      c = written_col[k];
    end else begin
      r = 6'($urandom);
      c = 11'($urandom);
    end
    send(OP_READ, 20'($urandom), 20'($urandom), 8'($urandom), r, c);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    int pick;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 55) send_point();
      else if (pick < 90) send_read();
      else if (pick < 96) send(OP_FRAME, 20'($urandom), 20'($urandom), 8'($urandom),
                               6'($urandom), 11'($urandom));
      else send(OP_NOP, 20'($urandom), 20'($urandom), 8'($urandom), 6'($urandom),
                11'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    hold_off_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    item.valid = 1'b0;
    item.op = OP_NOP;
    item.x_mm = '0;
    item.y_mm = '0;
    item.ring = '0;
    item.pixel_row = '0;
    item.pixel_col = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_ROWS;
    cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, origin, every op, out-of-bounds reads, invalid scale
    send(OP_READ, '0, '0, '0, 6'd0, 11'd0);
    send(OP_POINT, '0, '0, 8'd0, '0, '0);
    send(OP_POINT, 20'sh80000, 20'sh80000, 8'd63, '0, '0);
    send(OP_POINT, 20'sh7FFFF, 20'sh7FFFF, 8'd1, '0, '0);
    send(OP_POINT, 20'sh7FFFF, 20'sh80000, 8'd2, '0, '0);
    send(OP_POINT, 20'sh80000, 20'sh7FFFF, 8'd3, '0, '0);
    send(OP_POINT, 20'sd1000, 20'sd0, 8'd64, '0, '0);
    send(OP_POINT, 20'sd0, -20'sd1000, 8'd255, '0, '0);
    send(OP_POINT, -20'sd1000, 20'sd0, 8'd5, '0, '0);
    send(OP_POINT, 20'sd0, 20'sd1000, 8'd6, '0, '0);
    send(OP_READ, '0, '0, '0, 6'd63, 11'd2047);
    send(OP_READ, '1, '1, '1, 6'd0, 11'd900);
    send(OP_FRAME, '0, '0, '0, '0, '0);
    send(OP_READ, '0, '0, '0, 6'd0, 11'd900);
    send(OP_NOP, '1, '1, '1, '1, '1);
    send(OP_POINT, 20'sd500, 20'sd500, 8'd7, '0, '0);
    send(OP_READ, '0, '0, '0, 6'd7, 11'd1125);
    drain();

    for (int i = 0; i < 40; i++) begin
      written_row.push_back(6'($urandom_range(15)));
      written_col.push_back(11'($urandom_range(1799)));
    end

    random_phase(100, 0, 0);
    drain();
    write_reg(REG_ROWS, 12'd1);
    write_reg(REG_COLS, 12'd2);
    random_phase(60, 49, 0);
    drain();
    write_reg(REG_ROWS, 12'd127);
    write_reg(REG_COLS, 12'd4095);
    random_phase(80, 0, 49);
    drain();
    write_reg(REG_ROWS, 12'd0);
    write_reg(REG_COLS, 12'd0);
    random_phase(30, 12, 12);
    drain();
    write_reg(REG_ROWS, 12'd16);
    write_reg(REG_COLS, 12'd2048);
    hold_off_cycles = 600;
    random_phase(40, 0, 0);
    drain();
    write_reg(REG_ROWS, 12'd64);
    write_reg(REG_COLS, 12'd360);
    random_phase(160, 12, 12);
    drain();
    write_reg(REG_COLS, 12'd1800);
    random_phase(160, 0, 0);
    drain();

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
